@@ design/obb_pkg.sv @@
// ----------------------------------------------------------------------------
// obb_pkg
// Types, constants and helper functions for the oriented box overlap test.
// ----------------------------------------------------------------------------
package obb_pkg;

	localparam int COORD_BITS    = 24;
	localparam int ANGLE_BITS    = 16;
	localparam int TRIG_BITS     = 13;
	localparam int CORDIC_STEPS  = 16;
	localparam int CORDIC_FRAC   = 30;
	localparam int CORDIC_K      = 652032874;
	localparam int STEPS_PER_STG = 2;
	localparam int CSTG          = CORDIC_STEPS / STEPS_PER_STG;

	// CORDIC vector and angle widths
	localparam int CW = CORDIC_FRAC + 3;
	localparam int ZW = CORDIC_FRAC + 2;
	localparam int RSH = CORDIC_FRAC - TRIG_BITS;
	// rounded trig value, center difference, squared-trig magnitude
	localparam int TW  = TRIG_BITS + 3;
	localparam int DW  = COORD_BITS + 1;
	localparam int PW  = 2 * TW;
	localparam int NW  = 2 * TW - 1;
	localparam int DPW = DW + TW;
	localparam int TDW = DPW + 1;
	localparam int SLW = COORD_BITS + NW;
	localparam int LW  = SLW + 2;
	localparam int SH  = TRIG_BITS + 1;
	localparam int MW  = (TDW + SH > LW) ? (TDW + SH) : LW;

	// stage indexes (0 is the input register)
	localparam int ST_TRIG  = CSTG + 1;
	localparam int ST_PROD  = CSTG + 2;
	localparam int ST_SUM   = CSTG + 3;
	localparam int ST_SCALE = CSTG + 4;
	localparam int ST_BOUND = CSTG + 5;
	localparam int ST_TEST  = CSTG + 6;
	localparam int NSTG     = CSTG + 7;

	typedef enum logic [1:0] {Q_I, Q_II, Q_III, Q_IV} quad_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] a_center_x;
		logic signed [COORD_BITS-1:0] a_center_y;
		logic [COORD_BITS-1:0]        a_width;
		logic [COORD_BITS-1:0]        a_height;
		logic [ANGLE_BITS-1:0]        a_angle;
		logic signed [COORD_BITS-1:0] b_center_x;
		logic signed [COORD_BITS-1:0] b_center_y;
		logic [COORD_BITS-1:0]        b_width;
		logic [COORD_BITS-1:0]        b_height;
		logic [ANGLE_BITS-1:0]        b_angle;
	} in_t;

	typedef struct packed {
		logic hit;
		logic degenerate;
	} out_t;

	typedef struct packed {
		logic signed [DW-1:0]  dx;
		logic signed [DW-1:0]  dy;
		logic [COORD_BITS-1:0] wa;
		logic [COORD_BITS-1:0] ha;
		logic [COORD_BITS-1:0] wb;
		logic [COORD_BITS-1:0] hb;
		logic                  deg;
	} side_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
		quad_t                quad;
	} cord_t;

	typedef struct packed {
		logic signed [TW-1:0] c;
		logic signed [TW-1:0] s;
	} trig_t;

	typedef struct packed {
		logic signed [PW-1:0]  cc_a, ss_a, cc_b, ss_b;
		logic signed [PW-1:0]  cacb, sasb, cbsa, sbca;
		logic signed [DPW-1:0] dxca, dysa, dxsa, dyca;
		logic signed [DPW-1:0] dxcb, dysb, dxsb, dycb;
	} prod_t;

	typedef struct packed {
		logic [NW-1:0]           na, nb, pabs, qabs;
		logic [3:0][TDW-1:0]     tabs;
	} sum_t;

	typedef struct packed {
		logic [SLW-1:0]          wa_na, ha_na, wb_nb, hb_nb;
		logic [SLW-1:0]          wa_p, ha_q, wa_q, ha_p;
		logic [SLW-1:0]          wb_p, hb_q, wb_q, hb_p;
		logic [3:0][TDW-1:0]     tabs;
	} scale_t;

	typedef struct packed {
		logic [3:0][LW-1:0]      rhs;
		logic [3:0][TDW-1:0]     tabs;
	} bound_t;

	function automatic logic signed [ZW-1:0] atan_val(input int i);
		logic signed [ZW-1:0] v;
		case (i)
			0:  v = ZW'(536870912);
			1:  v = ZW'(316933405);
			2:  v = ZW'(167458907);
			3:  v = ZW'(85004756);
			4:  v = ZW'(42667331);
			5:  v = ZW'(21354465);
			6:  v = ZW'(10679838);
			7:  v = ZW'(5340245);
			8:  v = ZW'(2670163);
			9:  v = ZW'(1335086);
			10: v = ZW'(667544);
			11: v = ZW'(333772);
			12: v = ZW'(166886);
			13: v = ZW'(83443);
			14: v = ZW'(41721);
			15: v = ZW'(20860);
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic cord_t cord_init(input logic [ANGLE_BITS-1:0] ang);
		logic [31:0] a32;
		cord_t c;
		a32 = {ang, (32 - ANGLE_BITS)'(0)};
		c.x = CW'(CORDIC_K);
		c.y = '0;
		c.z = ZW'(a32[CORDIC_FRAC-1:0]);
		c.quad = quad_t'(a32[31:30]);
		return c;
	endfunction

	function automatic cord_t cord_step(input cord_t c, input int i);
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		cord_t r;
		dx = c.y >>> i;
		dy = c.x >>> i;
		r = c;
		if (!c.z[ZW-1]) begin
			r.x = c.x - dx;
			r.y = c.y + dy;
			r.z = c.z - atan_val(i);
		end else begin
			r.x = c.x + dx;
			r.y = c.y - dy;
			r.z = c.z + atan_val(i);
		end
		return r;
	endfunction

	// round half up to TRIG_BITS and unfold the quadrant
	function automatic trig_t trig_map(input cord_t c);
		logic signed [CW-1:0] xr;
		logic signed [CW-1:0] yr;
		logic signed [TW-1:0] cv;
		logic signed [TW-1:0] sv;
		trig_t t;
		xr = c.x + CW'(2 ** (RSH - 1));
		yr = c.y + CW'(2 ** (RSH - 1));
		cv = TW'(xr >>> RSH);
		sv = TW'(yr >>> RSH);
		case (c.quad)
			Q_I:   begin t.c = cv;  t.s = sv;  end
			Q_II:  begin t.c = -sv; t.s = cv;  end
			Q_III: begin t.c = -cv; t.s = -sv; end
			default: begin t.c = sv; t.s = -cv; end
		endcase
		return t;
	endfunction

endpackage

@@ design/obb_if.sv @@
// ----------------------------------------------------------------------------
// obb_if
// Valid/ready channels for box pairs and for test results.
// ----------------------------------------------------------------------------
interface obb_in_if;
	logic          valid;
	logic          ready;
	obb_pkg::in_t  data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface obb_out_if;
	logic          valid;
	logic          ready;
	obb_pkg::out_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ design/obb2d_intersection_test.sv @@
// Throughput: one box pair per cycle while result.ready is high; each stage advances on its own, so
// bubbles close up behind a stalled result.
// Rate is set by the 8-stage CORDIC (two rotations per stage) and the
// projection stages behind it, all fully pipelined.
// Reset clears all stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// obb2d_intersection_test
// Separating-axis overlap test for two oriented rectangles, pipelined.
// ----------------------------------------------------------------------------
module obb2d_intersection_test (
	input  logic            clk,
	input  logic            arst_n,
	obb_in_if.sink          boxes,
	obb_out_if.source       result
);

	localparam int ST_PRODM1 = obb_pkg::ST_PROD - 1;
	localparam int ST_SCALEM1 = obb_pkg::ST_SCALE - 1;
	localparam int ST_TESTM1 = obb_pkg::ST_TEST - 1;

	logic [obb_pkg::NSTG-1:0] v_s;
	logic [obb_pkg::NSTG-1:0] stg_ld;

	obb_pkg::side_t side_s [0:obb_pkg::NSTG-2];
	obb_pkg::cord_t cord_a_s [0:obb_pkg::CSTG];
	obb_pkg::cord_t cord_b_s [0:obb_pkg::CSTG];

	obb_pkg::trig_t  ta_s10, tb_s10;
	obb_pkg::prod_t  prod_s11;
	obb_pkg::sum_t   sum_s12;
	obb_pkg::scale_t scale_s13;
	obb_pkg::bound_t bound_s14;
	obb_pkg::out_t   res_s15;

	// a stage loads when empty or when the stage after it moves
	always_comb begin
		stg_ld[obb_pkg::NSTG-1] = !v_s[obb_pkg::NSTG-1] || result.ready;
		for (int i = obb_pkg::NSTG - 2; i >= 0; i--) begin
			stg_ld[i] = !v_s[i] || stg_ld[i+1];
		end
	end

	assign boxes.ready  = stg_ld[0];
	assign result.valid = v_s[obb_pkg::NSTG-1];
	assign result.data  = res_s15;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (stg_ld[0])
				v_s[0] <= boxes.valid;
			for (int i = 1; i < obb_pkg::NSTG; i++) begin
				if (stg_ld[i])
					v_s[i] <= v_s[i-1];
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (stg_ld[0]) begin
			side_s[0].dx  <= obb_pkg::DW'(boxes.data.b_center_x)
			                 - obb_pkg::DW'(boxes.data.a_center_x);
			side_s[0].dy  <= obb_pkg::DW'(boxes.data.b_center_y)
			                 - obb_pkg::DW'(boxes.data.a_center_y);
			side_s[0].wa  <= boxes.data.a_width;
			side_s[0].ha  <= boxes.data.a_height;
			side_s[0].wb  <= boxes.data.b_width;
			side_s[0].hb  <= boxes.data.b_height;
			side_s[0].deg <= (boxes.data.a_width == '0) || (boxes.data.a_height == '0)
			                 || (boxes.data.b_width == '0) || (boxes.data.b_height == '0);
			cord_a_s[0]   <= obb_pkg::cord_init(boxes.data.a_angle);
			cord_b_s[0]   <= obb_pkg::cord_init(boxes.data.b_angle);
		end
	end

	// side data rides along with the item
	for (genvar g = 1; g <= obb_pkg::NSTG - 2; g++) begin : g_side
		always_ff @(posedge clk) begin
			if (stg_ld[g])
				side_s[g] <= side_s[g-1];
		end
	end

	// CORDIC rotation stages
	for (genvar g = 1; g <= obb_pkg::CSTG; g++) begin : g_cord
		obb_pkg::cord_t na, nb;
		always_comb begin
			na = cord_a_s[g-1];
			nb = cord_b_s[g-1];
			for (int k = 0; k < obb_pkg::STEPS_PER_STG; k++) begin
				na = obb_pkg::cord_step(na, (g - 1) * obb_pkg::STEPS_PER_STG + k);
				nb = obb_pkg::cord_step(nb, (g - 1) * obb_pkg::STEPS_PER_STG + k);
			end
		end
		always_ff @(posedge clk) begin
			if (stg_ld[g]) begin
				cord_a_s[g] <= na;
				cord_b_s[g] <= nb;
			end
		end
	end

	// round and unfold cos/sin
	always_ff @(posedge clk) begin
		if (stg_ld[obb_pkg::ST_TRIG]) begin
			ta_s10 <= obb_pkg::trig_map(cord_a_s[obb_pkg::CSTG]);
			tb_s10 <= obb_pkg::trig_map(cord_b_s[obb_pkg::CSTG]);
		end
	end

	// trig cross products and center projections
	always_ff @(posedge clk) begin
		if (stg_ld[obb_pkg::ST_PROD]) begin
			prod_s11.cc_a <= ta_s10.c * ta_s10.c;
			prod_s11.ss_a <= ta_s10.s * ta_s10.s;
			prod_s11.cc_b <= tb_s10.c * tb_s10.c;
			prod_s11.ss_b <= tb_s10.s * tb_s10.s;
			prod_s11.cacb <= ta_s10.c * tb_s10.c;
			prod_s11.sasb <= ta_s10.s * tb_s10.s;
			prod_s11.cbsa <= tb_s10.c * ta_s10.s;
			prod_s11.sbca <= tb_s10.s * ta_s10.c;
			prod_s11.dxca <= side_s[ST_PRODM1].dx * ta_s10.c;
			prod_s11.dysa <= side_s[ST_PRODM1].dy * ta_s10.s;
			prod_s11.dxsa <= side_s[ST_PRODM1].dx * ta_s10.s;
			prod_s11.dyca <= side_s[ST_PRODM1].dy * ta_s10.c;
			prod_s11.dxcb <= side_s[ST_PRODM1].dx * tb_s10.c;
			prod_s11.dysb <= side_s[ST_PRODM1].dy * tb_s10.s;
			prod_s11.dxsb <= side_s[ST_PRODM1].dx * tb_s10.s;
			prod_s11.dycb <= side_s[ST_PRODM1].dy * tb_s10.c;
		end
	end

	// squared lengths, cross terms and absolute center projections
	logic signed [obb_pkg::PW:0]   pv, qv;
	logic [obb_pkg::PW:0]          pav, qav;
	logic signed [obb_pkg::TDW-1:0] tv [0:3];
	logic [3:0][obb_pkg::TDW-1:0]  tav;

	always_comb begin
		pv = (obb_pkg::PW + 1)'(prod_s11.cacb) + (obb_pkg::PW + 1)'(prod_s11.sasb);
		qv = (obb_pkg::PW + 1)'(prod_s11.cbsa) - (obb_pkg::PW + 1)'(prod_s11.sbca);
		pav = pv[obb_pkg::PW] ? -pv : pv;
		qav = qv[obb_pkg::PW] ? -qv : qv;
		tv[0] = obb_pkg::TDW'(prod_s11.dxca) + obb_pkg::TDW'(prod_s11.dysa);
		tv[1] = obb_pkg::TDW'(prod_s11.dyca) - obb_pkg::TDW'(prod_s11.dxsa);
		tv[2] = obb_pkg::TDW'(prod_s11.dxcb) + obb_pkg::TDW'(prod_s11.dysb);
		tv[3] = obb_pkg::TDW'(prod_s11.dycb) - obb_pkg::TDW'(prod_s11.dxsb);
		for (int k = 0; k < 4; k++) begin
			tav[k] = tv[k][obb_pkg::TDW-1] ? -tv[k] : tv[k];
		end
	end

	always_ff @(posedge clk) begin
		if (stg_ld[obb_pkg::ST_SUM]) begin
			sum_s12.na   <= obb_pkg::NW'(prod_s11.cc_a + prod_s11.ss_a);
			sum_s12.nb   <= obb_pkg::NW'(prod_s11.cc_b + prod_s11.ss_b);
			sum_s12.pabs <= obb_pkg::NW'(pav);
			sum_s12.qabs <= obb_pkg::NW'(qav);
			sum_s12.tabs <= tav;
		end
	end

	// scale by the box sizes
	always_ff @(posedge clk) begin
		if (stg_ld[obb_pkg::ST_SCALE]) begin
			scale_s13.wa_na <= side_s[ST_SCALEM1].wa * sum_s12.na;
			scale_s13.ha_na <= side_s[ST_SCALEM1].ha * sum_s12.na;
			scale_s13.wb_nb <= side_s[ST_SCALEM1].wb * sum_s12.nb;
			scale_s13.hb_nb <= side_s[ST_SCALEM1].hb * sum_s12.nb;
			scale_s13.wa_p  <= side_s[ST_SCALEM1].wa * sum_s12.pabs;
			scale_s13.ha_q  <= side_s[ST_SCALEM1].ha * sum_s12.qabs;
			scale_s13.wa_q  <= side_s[ST_SCALEM1].wa * sum_s12.qabs;
			scale_s13.ha_p  <= side_s[ST_SCALEM1].ha * sum_s12.pabs;
			scale_s13.wb_p  <= side_s[ST_SCALEM1].wb * sum_s12.pabs;
			scale_s13.hb_q  <= side_s[ST_SCALEM1].hb * sum_s12.qabs;
			scale_s13.wb_q  <= side_s[ST_SCALEM1].wb * sum_s12.qabs;
			scale_s13.hb_p  <= side_s[ST_SCALEM1].hb * sum_s12.pabs;
			scale_s13.tabs  <= sum_s12.tabs;
		end
	end

	// half extent of both boxes along each axis
	always_ff @(posedge clk) begin
		if (stg_ld[obb_pkg::ST_BOUND]) begin
			bound_s14.rhs[0] <= obb_pkg::LW'(scale_s13.wa_na) + obb_pkg::LW'(scale_s13.wb_p)
			                    + obb_pkg::LW'(scale_s13.hb_q);
			bound_s14.rhs[1] <= obb_pkg::LW'(scale_s13.ha_na) + obb_pkg::LW'(scale_s13.wb_q)
			                    + obb_pkg::LW'(scale_s13.hb_p);
			bound_s14.rhs[2] <= obb_pkg::LW'(scale_s13.wb_nb) + obb_pkg::LW'(scale_s13.wa_p)
			                    + obb_pkg::LW'(scale_s13.ha_q);
			bound_s14.rhs[3] <= obb_pkg::LW'(scale_s13.hb_nb) + obb_pkg::LW'(scale_s13.wa_q)
			                    + obb_pkg::LW'(scale_s13.ha_p);
			bound_s14.tabs   <= scale_s13.tabs;
		end
	end

	// touching counts as overlap
	logic [3:0] ax_ok;
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			ax_ok[k] = (obb_pkg::MW'(bound_s14.tabs[k]) << obb_pkg::SH)
			           <= obb_pkg::MW'(bound_s14.rhs[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (stg_ld[obb_pkg::ST_TEST]) begin
			res_s15.degenerate <= side_s[ST_TESTM1].deg;
			res_s15.hit        <= !side_s[ST_TESTM1].deg && (&ax_ok);
		end
	end

`ifndef ASSERT_OFF
	a_deg_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.degenerate |-> !result.data.hit)
		else $error("degenerate result reports a hit");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s[0] |-> boxes.ready)
		else $error("input refused with empty first stage");

	a_hold_first: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[0] && !stg_ld[0] |=> v_s[0] && $stable(side_s[0]))
		else $error("stalled first stage lost its item");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid && $stable(res_s15))
		else $error("stalled result changed");
`endif

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives box pairs into the oriented box overlap test under several
// valid/ready idling mixes, and checks every hit/degenerate result against a
// bit-exact separating-axis predictor built on a 16-step CORDIC.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int RANDOM_PAIRS = 2000;
	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 40;
	localparam longint ATAN_K[obb_pkg::CORDIC_STEPS] = '{
		536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335086, 667544, 333772,
		166886, 83443, 41721, 20860
	};
	localparam int CSIGN_X[4] = '{-1, 1, 1, -1};
	localparam int CSIGN_Y[4] = '{-1, -1, 1, 1};

	typedef struct {
		longint cx[4];
		longint cy[4];
		longint ux[2];
		longint uy[2];
		longint len[2];
	} rect_t;

	typedef struct {
		obb_pkg::in_t  pair;
		bit            known;
		obb_pkg::out_t res;
	} row_t;

	logic clk;
	logic arst_n;
	obb_in_if  boxes();
	obb_out_if result();

	obb2d_intersection_test uut (
		.clk(clk),
		.arst_n(arst_n),
		.boxes(boxes.sink),
		.result(result.source)
	);

	obb_pkg::out_t hit_q[$];
	int     fails;
	int     src_idle;
	int     dst_idle;
	int     quiet;
	row_t   rows[$];

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic void sincos(input logic [obb_pkg::ANGLE_BITS-1:0] ang,
		output longint c, output longint s);
		logic [31:0] a;
		longint x, y, z, dx, dy, cv, sv;
		a = {ang, 16'h0};
		x = obb_pkg::CORDIC_K;
		y = 0;
		z = longint'(a[29:0]);
		for (int i = 0; i < obb_pkg::CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN_K[i];
			end else begin
				x += dx; y -= dy; z += ATAN_K[i];
			end
		end
		cv = (x + (64'sd1 <<< (obb_pkg::RSH - 1))) >>> obb_pkg::RSH;
		sv = (y + (64'sd1 <<< (obb_pkg::RSH - 1))) >>> obb_pkg::RSH;
		case (obb_pkg::quad_t'(a[31:30]))
			obb_pkg::Q_I: begin c = cv; s = sv; end
			obb_pkg::Q_II: begin c = -sv; s = cv; end
			obb_pkg::Q_III: begin c = -cv; s = -sv; end
			default: begin c = sv; s = -cv; end
		endcase
	endfunction

	function automatic rect_t make_rect(input longint px, input longint py,
		input longint w, input longint h, input logic [obb_pkg::ANGLE_BITS-1:0] ang);
		rect_t r;
		longint c, s, xx, xy, yx, yy;
		sincos(ang, c, s);
		xx = c * w; xy = s * w;
		yx = -s * h; yy = c * h;
		for (int k = 0; k < 4; k++) begin
			r.cx[k] = px * (2 << obb_pkg::TRIG_BITS) + CSIGN_X[k] * xx + CSIGN_Y[k] * yx;
			r.cy[k] = py * (2 << obb_pkg::TRIG_BITS) + CSIGN_X[k] * xy + CSIGN_Y[k] * yy;
		end
		r.ux[0] = c;  r.uy[0] = s; r.len[0] = w;
		r.ux[1] = -s; r.uy[1] = c; r.len[1] = h;
		return r;
	endfunction

	// project b onto both edge axes of a; touching counts as overlap
	function automatic bit spans_overlap(input rect_t a, input rect_t b);
		longint lim, lo, hi, d;
		for (int ax = 0; ax < 2; ax++) begin
			lim = 2 * a.len[ax] * (a.ux[ax] * a.ux[ax] + a.uy[ax] * a.uy[ax]);
			lo = 0;
			hi = 0;
			for (int k = 0; k < 4; k++) begin
				d = (b.cx[k] - a.cx[0]) * a.ux[ax] + (b.cy[k] - a.cy[0]) * a.uy[ax];
				if (k == 0 || d < lo) lo = d;
				if (k == 0 || d > hi) hi = d;
			end
			if (lo > lim || hi < 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic obb_pkg::out_t sat_test(input obb_pkg::in_t p);
		obb_pkg::out_t o;
		rect_t ra, rb;
		if (p.a_width == 0 || p.a_height == 0 || p.b_width == 0 || p.b_height == 0) begin
			o.hit = 1'b0;
			o.degenerate = 1'b1;
			return o;
		end
		ra = make_rect(longint'(p.a_center_x), longint'(p.a_center_y),
			longint'(p.a_width), longint'(p.a_height), p.a_angle);
		rb = make_rect(longint'(p.b_center_x), longint'(p.b_center_y),
			longint'(p.b_width), longint'(p.b_height), p.b_angle);
		o.hit = spans_overlap(ra, rb) && spans_overlap(rb, ra);
		o.degenerate = 1'b0;
		return o;
	endfunction

	function automatic obb_pkg::in_t mk_pair(int acx, int acy, int aw, int ah, int aang,
		int bcx, int bcy, int bw, int bh, int bang);
		obb_pkg::in_t p;
		p.a_center_x = obb_pkg::COORD_BITS'(acx);
		p.a_center_y = obb_pkg::COORD_BITS'(acy);
		p.a_width = obb_pkg::COORD_BITS'(aw);
		p.a_height = obb_pkg::COORD_BITS'(ah);
		p.a_angle = obb_pkg::ANGLE_BITS'(aang);
		p.b_center_x = obb_pkg::COORD_BITS'(bcx);
		p.b_center_y = obb_pkg::COORD_BITS'(bcy);
		p.b_width = obb_pkg::COORD_BITS'(bw);
		p.b_height = obb_pkg::COORD_BITS'(bh);
		p.b_angle = obb_pkg::ANGLE_BITS'(bang);
		return p;
	endfunction

	function automatic void add_row(obb_pkg::in_t p, bit known, bit hit, bit deg);
		row_t r;
		r.pair = p;
		r.known = known;
		r.res.hit = hit;
		r.res.degenerate = deg;
		rows.push_back(r);
	endfunction

	function automatic obb_pkg::in_t rand_pair();
		obb_pkg::in_t p;
		int sel;
		int span;
		sel = $urandom_range(99);
		p = obb_pkg::in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom});
		if (sel < 75) begin
			// nearby boxes of moderate size so hits and misses both occur
			span = 1 << $urandom_range(6, 16);
			p.a_width = obb_pkg::COORD_BITS'($urandom_range(1, span));
			p.a_height = obb_pkg::COORD_BITS'($urandom_range(1, span));
			p.b_width = obb_pkg::COORD_BITS'($urandom_range(1, span));
			p.b_height = obb_pkg::COORD_BITS'($urandom_range(1, span));
			p.b_center_x = obb_pkg::COORD_BITS'(p.a_center_x
				+ $signed($urandom_range(0, 2 * span)) - span);
			p.b_center_y = obb_pkg::COORD_BITS'(p.a_center_y
				+ $signed($urandom_range(0, 2 * span)) - span);
		end else if (sel < 80) begin
			case ($urandom_range(3))
				0: p.a_width = '0;
				1: p.a_height = '0;
				2: p.b_width = '0;
				default: p.b_height = '0;
			endcase
		end
		return p;
	endfunction

	task automatic send_pair(input obb_pkg::in_t p);
		while ($urandom_range(99) < src_idle) begin
			boxes.valid <= 1'b0;
			@(negedge clk);
		end
		boxes.valid <= 1'b1;
		boxes.data <= p;
		do @(posedge clk); while (!boxes.ready);
		@(negedge clk);
	endtask

	// receiver back-pressure
	always @(negedge clk)
		result.ready <= ($urandom_range(99) >= dst_idle);

	// predict on input transfer, compare on output transfer
	always @(posedge clk) begin
		obb_pkg::out_t want;
		if (boxes.valid && boxes.ready)
			hit_q.push_back(sat_test(boxes.data));
		if (result.valid && result.ready) begin
			if (hit_q.size() == 0) begin
				$error("unexpected result hit=%0b degenerate=%0b",
					result.data.hit, result.data.degenerate);
				fails++;
			end else begin
				want = hit_q.pop_front();
				if (result.data.hit !== want.hit) begin
					$error("hit: expected %0b actual %0b", want.hit, result.data.hit);
					fails++;
				end
				if (result.data.degenerate !== want.degenerate) begin
					$error("degenerate: expected %0b actual %0b",
						want.degenerate, result.data.degenerate);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((boxes.valid && boxes.ready) || (result.valid && result.ready) || !arst_n)
			quiet <= 0;
		else if (quiet >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else
			quiet <= quiet + 1;
	end

	initial begin
		obb_pkg::in_t p;
		fails = 0;
		quiet = 0;
		src_idle = 12;
		dst_idle = 71;
		arst_n = 1'b0;
		boxes.valid = 1'b0;
		boxes.data = '0;
		result.ready = 1'b0;

		// degenerate sizes: any zero edge forces no hit
		add_row(mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, 1'b0, 1'b1);
		add_row(mk_pair(0, 0, 0, 256, 0, 0, 0, 256, 256, 0), 1'b1, 1'b0, 1'b1);
		add_row(mk_pair(0, 0, 256, 0, 0, 0, 0, 256, 256, 0), 1'b1, 1'b0, 1'b1);
		add_row(mk_pair(0, 0, 256, 256, 0, 0, 0, 0, 256, 0), 1'b1, 1'b0, 1'b1);
		add_row(mk_pair(0, 0, 256, 256, 0, 0, 0, 256, 0, 0), 1'b1, 1'b0, 1'b1);
		add_row(mk_pair(-8388608, 8388607, 16777215, 0, 65535,
			8388607, -8388608, 16777215, 16777215, 65535), 1'b1, 1'b0, 1'b1);
		// identical and far-apart boxes
		add_row(mk_pair(0, 0, 256, 256, 0, 0, 0, 256, 256, 0), 1'b0, 1'b0, 1'b0);
		add_row(mk_pair(-8388608, -8388608, 1, 1, 0, 8388607, 8388607, 1, 1, 0),
			1'b0, 1'b0, 1'b0);
		add_row(mk_pair(-8388608, -8388608, 16777215, 16777215, 0,
			8388607, 8388607, 16777215, 16777215, 0), 1'b0, 1'b0, 1'b0);
		add_row(mk_pair(8388607, 8388607, 16777215, 16777215, 65535,
			-8388608, -8388608, 16777215, 16777215, 32768), 1'b0, 1'b0, 1'b0);
		// edges that just touch, and just miss
		add_row(mk_pair(0, 0, 256, 256, 0, 256, 0, 256, 256, 0), 1'b0, 1'b0, 1'b0);
		add_row(mk_pair(0, 0, 256, 256, 0, 257, 0, 256, 256, 0), 1'b0, 1'b0, 1'b0);
		add_row(mk_pair(0, 0, 256, 256, 0, 0, -256, 256, 256, 0), 1'b0, 1'b0, 1'b0);
		// quadrant boundaries and rotated near-misses
		add_row(mk_pair(0, 0, 1024, 64, 16384, 0, 520, 64, 64, 0), 1'b0, 1'b0, 1'b0);
		add_row(mk_pair(0, 0, 1024, 64, 32768, 520, 0, 64, 64, 49152), 1'b0, 1'b0, 1'b0);
		add_row(mk_pair(0, 0, 1024, 64, 49152, 0, -520, 64, 64, 8192), 1'b0, 1'b0, 1'b0);
		add_row(mk_pair(0, 0, 1024, 64, 65535, 500, 0, 64, 64, 24576), 1'b0, 1'b0, 1'b0);
		add_row(mk_pair(0, 0, 2048, 64, 8192, 700, 700, 64, 64, 0), 1'b0, 1'b0, 1'b0);
		add_row(mk_pair(0, 0, 2048, 64, 8192, 700, -700, 64, 64, 40960), 1'b0, 1'b0, 1'b0);
		add_row(mk_pair(100, -100, 1, 16777215, 4096, -100, 100, 16777215, 1, 61440),
			1'b0, 1'b0, 1'b0);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			if (rows[i].known && sat_test(rows[i].pair) != rows[i].res) begin
				$error("table row %0d: predictor disagrees with listed result", i);
				fails++;
			end
			send_pair(rows[i].pair);
		end

		for (int ph = 0; ph < 3; ph++) begin
			src_idle = (ph == 0) ? 12 : (ph == 1) ? 71 : 0;
			dst_idle = (ph == 0) ? 71 : (ph == 1) ? 12 : 0;
			for (int n = 0; n < RANDOM_PAIRS / 3; n++) begin
				p = rand_pair();
				send_pair(p);
			end
		end
		boxes.valid <= 1'b0;

		wait (hit_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ obb2d_intersection_test.f @@
design/obb_pkg.sv
design/obb_if.sv
design/obb2d_intersection_test.sv
dv/tb_top.sv
